>>> hw/rtl/hrt_pkg.sv
// Shared types and constants for the hysteresis reference tracker.
`timescale 1ns / 1ps

package hrt_pkg;

  localparam int CH_W      = 6;
  localparam int CH_COUNT  = 64;
  localparam int SAMPLE_W  = 32;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BUY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BUY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SELL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SELL  = 2'd3;

  localparam logic [COEF_W-1:0] START_BUY_RST  = 16'd655;
  localparam logic [COEF_W-1:0] STEP_BUY_RST   = 16'd66;
  localparam logic [COEF_W-1:0] START_SELL_RST = 16'd655;
  localparam logic [COEF_W-1:0] STEP_SELL_RST  = 16'd66;

  typedef struct packed {
    logic [COEF_W-1:0] start_buy;
    logic [COEF_W-1:0] step_buy;
    logic [COEF_W-1:0] start_sell;
    logic [COEF_W-1:0] step_sell;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                sell;
  } chan_state_t;

  localparam chan_state_t CHAN_STATE_RST = '{level: '0, sell: 1'b1};

endpackage

>>> hw/rtl/hysteresis_reference_tracker.sv
// Top level of the hysteresis reference tracker.
`timescale 1ns / 1ps

// Tracks one reference level and a selling/buying mode per channel. Every
// request returns exactly one result, in order: the channel's reference and
// mode after applying the sample (a zero sample only reports the state). The
// block takes one request per clock unless the output stalls; a result
// passes the input stage (restart multipliers), the state memory read plus
// approach multiplier and the output register. Back-to-back requests on
// one channel are served through a last-write bypass around the state memory.
// Stalls on the output back up through the three stages. No clearing pass is
// needed after reset: per-channel seen bits reset with the block.
module hysteresis_reference_tracker import hrt_pkg::*; #(
  parameter int CHANNELS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CH_W-1:0]      channel,
  input  logic [SAMPLE_W-1:0]  sample,
  input  logic                 row_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CH_W-1:0]      out_channel,
  output logic [SAMPLE_W-1:0]  reference,
  output logic                 selling,
  output logic                 out_row_end
);

  localparam int DEPTH = (CHANNELS < CH_COUNT) ? CHANNELS : CH_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  logic                s1_valid;
  logic [CH_W-1:0]     s1_channel;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_row_end;
  logic [SAMPLE_W-1:0] s1_below;
  logic [SAMPLE_W-1:0] s1_above;
  logic                s1_in_range;

  logic                s2_valid;
  logic [CH_W-1:0]     s2_channel;
  logic [SAMPLE_W-1:0] s2_sample;
  logic                s2_row_end;
  logic [SAMPLE_W-1:0] s2_below;
  logic [SAMPLE_W-1:0] s2_above;
  logic                s2_in_range;

  logic        out_adv;
  logic        s2_free;
  logic        s1_adv;
  logic        cur_seen;
  chan_state_t cur_state;
  chan_state_t upd_state;
  logic        upd_wr;

  assign cfg_ready = 1'b1;

  hrt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_adv  = s2_valid && (!out_valid || out_ready);
  assign s2_free  = !s2_valid || out_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;

  // Stage 1: request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_channel <= channel;
      s1_sample  <= sample;
      s1_row_end <= row_end;
    end
  end

  hrt_start_calc u_start (
    .sample     (s1_sample),
    .start_buy  (cfg.start_buy),
    .start_sell (cfg.start_sell),
    .below      (s1_below),
    .above      (s1_above)
  );

  assign s1_in_range = {1'b0, s1_channel} < (CH_W + 1)'(DEPTH);

  // Stage 2: state lookup and update
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_channel  <= s1_channel;
      s2_sample   <= s1_sample;
      s2_row_end  <= s1_row_end;
      s2_below    <= s1_below;
      s2_above    <= s1_above;
      s2_in_range <= s1_in_range;
    end
  end

  hrt_state_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (s1_adv),
    .rd_addr   (s1_channel[AW-1:0]),
    .cur_addr  (s2_channel[AW-1:0]),
    .wr_en     (out_adv && upd_wr),
    .wr_state  (upd_state),
    .cur_seen  (cur_seen),
    .cur_state (cur_state)
  );

  hrt_update u_update (
    .sample    (s2_sample),
    .below     (s2_below),
    .above     (s2_above),
    .in_range  (s2_in_range),
    .seen      (cur_seen),
    .stored    (cur_state),
    .step_buy  (cfg.step_buy),
    .step_sell (cfg.step_sell),
    .result    (upd_state),
    .wr_needed (upd_wr)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_channel <= s2_channel;
      reference   <= upd_state.level;
      selling     <= upd_state.sell;
      out_row_end <= s2_row_end;
    end
  end

endmodule

>>> hw/rtl/hrt_cfg_regs.sv
// Coefficient registers written through the configuration port.
`timescale 1ns / 1ps

module hrt_cfg_regs import hrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COEF_W-1:0]    wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_buy  <= START_BUY_RST;
      cfg.step_buy   <= STEP_BUY_RST;
      cfg.start_sell <= START_SELL_RST;
      cfg.step_sell  <= STEP_SELL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_BUY:  cfg.start_buy  <= wr_data;
        REG_STEP_BUY:   cfg.step_buy   <= wr_data;
        REG_START_SELL: cfg.start_sell <= wr_data;
        REG_STEP_SELL:  cfg.step_sell  <= wr_data;
      endcase
    end
  end

endmodule

>>> hw/rtl/hrt_start_calc.sv
// Restart levels below and above a sample (first pipeline stage math).
`timescale 1ns / 1ps

module hrt_start_calc import hrt_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [COEF_W-1:0]   start_buy,
  input  logic [COEF_W-1:0]   start_sell,
  output logic [SAMPLE_W-1:0] below,
  output logic [SAMPLE_W-1:0] above
);

  logic [COEF_W:0]     below_coef;
  logic [48:0]         below_prod;
  logic [47:0]         above_prod;
  logic [SAMPLE_W:0]   above_sum;

  always_comb begin
    below_coef = 17'h10000 - {1'b0, start_sell};
    below_prod = {17'd0, sample} * {32'd0, below_coef};
    below      = below_prod[47:16];
    above_prod = {16'd0, sample} * {32'd0, start_buy};
    above_sum  = {1'b0, sample} + {1'b0, above_prod[47:16]};
    above      = above_sum[SAMPLE_W] ? '1 : above_sum[SAMPLE_W-1:0];
  end

endmodule

>>> hw/rtl/hrt_state_store.sv
// Per-channel reference/mode memory with seen bits and last-write bypass.
`timescale 1ns / 1ps

module hrt_state_store import hrt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] cur_addr,
  input  logic        wr_en,
  input  chan_state_t wr_state,
  output logic        cur_seen,
  output chan_state_t cur_state
);

  chan_state_t mem [DEPTH];
  chan_state_t rd_data;
  logic [DEPTH-1:0] seen;
  logic        lw_valid;
  logic [AW-1:0] lw_addr;
  chan_state_t lw_state;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur_addr] <= wr_state;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      seen[cur_addr] <= 1'b1;
      lw_valid       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr  <= cur_addr;
      lw_state <= wr_state;
    end
  end

  always_comb begin
    cur_seen = seen[cur_addr];
    if (!cur_seen) begin
      cur_state = CHAN_STATE_RST;
    end else if (lw_valid && (lw_addr == cur_addr)) begin
      cur_state = lw_state;
    end else begin
      cur_state = rd_data;
    end
  end

endmodule

>>> hw/rtl/hrt_update.sv
// Approach step and direction switch for one channel.
`timescale 1ns / 1ps

module hrt_update import hrt_pkg::*; (
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] below,
  input  logic [SAMPLE_W-1:0] above,
  input  logic                in_range,
  input  logic                seen,
  input  chan_state_t         stored,
  input  logic [COEF_W-1:0]   step_buy,
  input  logic [COEF_W-1:0]   step_sell,
  output chan_state_t         result,
  output logic                wr_needed
);

  logic [SAMPLE_W-1:0] start_level;
  logic                start_sell_mode;
  logic [COEF_W-1:0]   step;
  logic                up;
  logic [SAMPLE_W-1:0] diff;
  logic [47:0]         prod;
  logic [SAMPLE_W-1:0] moved;
  chan_state_t         updated;

  always_comb begin
    start_level     = seen ? stored.level : below;
    start_sell_mode = seen ? stored.sell : 1'b1;
    step            = start_sell_mode ? step_sell : step_buy;
    up              = sample >= start_level;
    diff            = up ? (sample - start_level) : (start_level - sample);
    prod            = {16'd0, diff} * {32'd0, step};
    moved           = up ? (start_level + prod[47:16]) : (start_level - prod[47:16]);

    if (start_sell_mode) begin
      if (sample <= moved) begin
        updated = '{level: above, sell: 1'b0};
      end else begin
        updated = '{level: moved, sell: 1'b1};
      end
    end else begin
      if (sample >= moved) begin
        updated = '{level: below, sell: 1'b1};
      end else begin
        updated = '{level: moved, sell: 1'b0};
      end
    end

    wr_needed = in_range && (sample != '0);
    priority if (!in_range) begin
      result = CHAN_STATE_RST;
    end else if (sample == '0) begin
      result = stored;
    end else begin
      result = updated;
    end
  end

endmodule

>>> hw/rtl/hrt_checker.sv
// Port-level checks for the hysteresis reference tracker, bound to the top.
`timescale 1ns / 1ps

module hrt_checker import hrt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CH_W-1:0]     out_channel,
  input logic [SAMPLE_W-1:0] reference,
  input logic                selling,
  input logic                out_row_end
);

  logic [2:0] in_flight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reference) && $stable(selling)
      && $stable(out_channel) && $stable(out_row_end))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_flight != 3'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'd3)
    else $error("more requests in flight than pipeline stages");

  a_buy_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !selling |-> reference != '0)
    else $error("buying mode with zero reference");

endmodule

bind hysteresis_reference_tracker hrt_checker u_hrt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_channel (out_channel),
  .reference   (reference),
  .selling     (selling),
  .out_row_end (out_row_end)
);

>>> bench/tb_hysteresis_reference_tracker.sv
// Self-checking bench for the hysteresis reference tracker: directed table, then random tracking.
`timescale 1ns / 1ps

module tb_hysteresis_reference_tracker;
  import hrt_pkg::*;

  localparam int PROD_W = SAMPLE_W + COEF_W + 1;
  localparam int NUM_DIR = 28;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_REQS = 124;

  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SAMPLE_W+COEF_W-1:0] wide_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [SAMPLE_W-1:0] level_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    level_t          level;
    logic            sell;
    logic            row_end;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    coef_t                coef;
    logic [CH_W-1:0]      ch;
    level_t               sample;
    logic                 row_end;
    logic                 pinned;
    level_t               pin_level;
    logic                 pin_sell;
  } dir_row_t;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd0,  32'h0000_0000, 1'b0, 1'b1, 32'h0, 1'b1},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd63, 32'h0000_0000, 1'b1, 1'b1, 32'h0, 1'b1},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd1000,      1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd2000,      1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd500,       1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd0,         1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd400,       1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd1,  32'd5000,      1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd2,  32'd1,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_START_SELL, 16'h0000, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_START_BUY,  16'hFFFF, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd3,  32'hFFFF_FFFF, 1'b0,
      1'b1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd3,  32'hFFFF_FFFF, 1'b1,
      1'b1, 32'hFFFF_FFFF, 1'b1},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd4,  32'd1,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_STEP_SELL,  16'hFFFF, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_STEP_BUY,   16'hFFFF, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd5,  32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd5,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd5,  32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_STEP_SELL,  16'h0000, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_STEP_BUY,   16'h0000, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_START_SELL, 16'hFFFF, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_CFG, REG_START_BUY,  16'h0000, 6'd0,  32'h0,         1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd6,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd6,  32'd2,         1'b1, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd3,  32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0},
    '{ROW_REQ, REG_START_BUY,  16'h0000, 6'd5,  32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_t                cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      channel = '0;
  level_t               sample = '0;
  logic                 row_end = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_channel;
  level_t               reference;
  logic                 selling;
  logic                 out_row_end;

  // predictor state
  coef_t   coef_start_buy  = START_BUY_RST;
  coef_t   coef_step_buy   = STEP_BUY_RST;
  coef_t   coef_start_sell = START_SELL_RST;
  coef_t   coef_step_sell  = STEP_SELL_RST;
  level_t  track_level [CH_COUNT];
  logic    track_sell  [CH_COUNT];
  logic    track_seen  [CH_COUNT];

  result_t expected_refs [$];
  result_t got_res;
  result_t want_res;

  logic    pin_active = 1'b0;
  level_t  pin_level = '0;
  logic    pin_sell = 1'b0;

  level_t  walk_level [CH_COUNT];
  logic [CH_W-1:0] hot_ch [4];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left = 0;
  int n_requests = 0;
  int n_absent = 0;
  int n_switches = 0;
  int n_checked = 0;
  int n_settings = 1;
  int n_faults = 0;

  hysteresis_reference_tracker u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .channel     (channel),
    .sample      (sample),
    .row_end     (row_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .reference   (reference),
    .selling     (selling),
    .out_row_end (out_row_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_hysteresis_reference_tracker NOT OK");
    $finish;
  end

  function automatic level_t start_below(level_t s);
    prod_t prod;
    prod = prod_t'(s) * (prod_t'(1 << COEF_W) - prod_t'(coef_start_sell));
    return prod[SAMPLE_W+COEF_W-1:COEF_W];
  endfunction

  function automatic level_t start_above(level_t s);
    prod_t prod;
    prod = prod_t'(s) * (prod_t'(1 << COEF_W) + prod_t'(coef_start_buy));
    return prod[PROD_W-1] ? '1 : prod[SAMPLE_W+COEF_W-1:COEF_W];
  endfunction

  function automatic level_t approach(level_t lvl, level_t s, coef_t rate);
    level_t gap;
    wide_t  prod;
    level_t delta;
    gap   = (s >= lvl) ? s - lvl : lvl - s;
    prod  = wide_t'(gap) * wide_t'(rate);
    delta = prod[SAMPLE_W+COEF_W-1:COEF_W];
    return (s >= lvl) ? lvl + delta : lvl - delta;
  endfunction

  function automatic result_t track_sample(logic [CH_W-1:0] ch, level_t s, logic re);
    level_t lvl;
    logic   sell;
    lvl  = track_level[ch];
    sell = track_sell[ch];
    if (s != '0) begin
      if (!track_seen[ch]) begin
        track_seen[ch] = 1'b1;
        lvl  = start_below(s);
        sell = 1'b1;
      end
      if (sell) begin
        lvl = approach(lvl, s, coef_step_sell);
        if (s <= lvl) begin
          lvl  = start_above(s);
          sell = 1'b0;
          n_switches++;
        end
      end else begin
        lvl = approach(lvl, s, coef_step_buy);
        if (s >= lvl) begin
          lvl  = start_below(s);
          sell = 1'b1;
          n_switches++;
        end
      end
      track_level[ch] = lvl;
      track_sell[ch]  = sell;
    end else begin
      n_absent++;
    end
    return '{ch: ch, level: lvl, sell: sell, row_end: re};
  endfunction

  // sampled at the falling edge so the handshake is settled
  always @(negedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_BUY:  coef_start_buy  = cfg_data;
          REG_STEP_BUY:   coef_step_buy   = cfg_data;
          REG_START_SELL: coef_start_sell = cfg_data;
          REG_STEP_SELL:  coef_step_sell  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want_res = track_sample(channel, sample, row_end);
        if (pin_active) begin
          want_res.level = pin_level;
          want_res.sell  = pin_sell;
        end
        expected_refs.push_back(want_res);
        n_requests++;
      end
      if (out_valid && out_ready) begin
        got_res = '{ch: out_channel, level: reference, sell: selling, row_end: out_row_end};
        if (expected_refs.size() == 0) begin
          n_faults++;
          if (n_faults <= 10)
            $display("unexpected result: ch=%0d ref=%h sell=%b row_end=%b",
                     got_res.ch, got_res.level, got_res.sell, got_res.row_end);
        end else begin
          want_res = expected_refs.pop_front();
          n_checked++;
          if (got_res !== want_res) begin
            n_faults++;
            if (n_faults <= 10)
              $display({"mismatch: expected ch=%0d ref=%h sell=%b row_end=%b,",
                        " got ch=%0d ref=%h sell=%b row_end=%b"},
                       want_res.ch, want_res.level, want_res.sell, want_res.row_end,
                       got_res.ch, got_res.level, got_res.sell, got_res.row_end);
          end
        end
      end
    end
  end

  // result side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_req(input logic [CH_W-1:0] ch, input level_t s, input logic re,
                          input logic pinned, input level_t plevel, input logic psell);
    pin_active = pinned;
    pin_level  = plevel;
    pin_sell   = psell;
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= s;
    row_end  <= re;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_refs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coef_t pick_coef(coef_t dflt);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return dflt;
      3: return coef_t'($urandom);
      default: return coef_t'($urandom_range(0, 3000));
    endcase
  endfunction

  // random walk per channel so references get crossed in both directions
  function automatic level_t wander_sample(logic [CH_W-1:0] ch);
    level_t mag;
    int     kind;
    kind = $urandom_range(0, 99);
    if (kind < 8) return '0;
    if (kind < 16) return $urandom;
    if (kind < 20) begin
      case ($urandom_range(0, 2))
        0: return 32'd1;
        1: return 32'hFFFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    mag = (walk_level[ch] >> $urandom_range(2, 12)) + $urandom_range(1, 8);
    if ($urandom_range(0, 1) && walk_level[ch] < 32'hF000_0000)
      walk_level[ch] = walk_level[ch] + mag;
    else if (walk_level[ch] > mag)
      walk_level[ch] = walk_level[ch] - mag;
    else
      walk_level[ch] = walk_level[ch] + mag;
    return walk_level[ch];
  endfunction

  initial begin
    logic [CH_W-1:0] ch;
    for (int i = 0; i < CH_COUNT; i++) begin
      track_level[i] = '0;
      track_sell[i]  = 1'b1;
      track_seen[i]  = 1'b0;
      walk_level[i]  = $urandom_range(1000, 32'h3FFF_FFFF);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_cfg(dir_rows[i].idx, dir_rows[i].coef);
      end else begin
        send_req(dir_rows[i].ch, dir_rows[i].sample, dir_rows[i].row_end,
                 dir_rows[i].pinned, dir_rows[i].pin_level, dir_rows[i].pin_sell);
        maybe_pause();
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      tx_idle_pct = (ph == NUM_PHASES - 1) ? 0 : (ph % 3) * 20;
      rx_idle_pct = (ph == NUM_PHASES - 1) ? 0 : ((ph + 1) % 3) * 20;
      write_cfg(REG_START_BUY,  pick_coef(START_BUY_RST));
      write_cfg(REG_STEP_BUY,   pick_coef(STEP_BUY_RST));
      write_cfg(REG_START_SELL, pick_coef(START_SELL_RST));
      write_cfg(REG_STEP_SELL,  pick_coef(STEP_SELL_RST));
      n_settings++;
      for (int k = 0; k < 4; k++) hot_ch[k] = CH_W'($urandom_range(0, CH_COUNT - 1));
      for (int k = 0; k < PHASE_REQS; k++) begin
        ch = $urandom_range(0, 1) ? hot_ch[2'($urandom_range(0, 3))]
                                  : CH_W'($urandom_range(0, CH_COUNT - 1));
        send_req(ch, wander_sample(ch), $urandom_range(0, 7) == 0, 1'b0, '0, 1'b0);
        maybe_pause();
      end
    end
    wait_drained();

    $display({"covered %0d requests (%0d absent samples, %0d mode switches)",
              " over %0d coefficient sets"},
             n_requests, n_absent, n_switches, n_settings);
    $display("checked %0d results, %0d faults", n_checked, n_faults);
    if (n_faults == 0 && expected_refs.size() == 0) begin
      $display("tb_hysteresis_reference_tracker OK");
    end else begin
      $display("tb_hysteresis_reference_tracker NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hrt_pkg.sv
hw/rtl/hrt_cfg_regs.sv
hw/rtl/hrt_start_calc.sv
hw/rtl/hrt_state_store.sv
hw/rtl/hrt_update.sv
hw/rtl/hysteresis_reference_tracker.sv
hw/rtl/hrt_checker.sv
bench/tb_hysteresis_reference_tracker.sv
